[rtl/core/bbr_pkg.sv]
// Shared types and constants for the 3x3 RGB box blur.
package bbr_pkg;

	localparam int CH_W     = 8;
	localparam int NUM_CH   = 3;
	localparam int PIX_W    = CH_W * NUM_CH;
	localparam int COL_W    = 10;
	localparam int SUM_W    = 12;
	localparam int N_W      = 4;
	localparam int WIDTH_W  = 11;
	localparam int HEIGHT_W = 13;
	localparam int CFG_W    = 13;
	localparam int CFG_IDX_W = 1;

	localparam logic OP_PUSH  = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

	typedef logic [NUM_CH-1:0][CH_W-1:0] pix_t;

	typedef struct packed {
		logic            emit;
		logic            last;
		logic [N_W-1:0]  n;
		logic [2:0]      row_ok;
		logic [2:0]      col_ok;
		logic [2:0][1:0] row_slot;
		logic [2:0][1:0] col_bank;
		logic [2:0][2:0] fwd;
		logic            we;
		logic [1:0]      wslot;
		logic [1:0]      wbank;
	} ctl_t;

	typedef struct packed {
		logic                         valid;
		logic                         last;
		logic [N_W-1:0]               n;
		logic [NUM_CH-1:0][SUM_W-1:0] rem;
		logic [NUM_CH-1:0][CH_W-1:0]  quo;
	} div_t;

endpackage

[rtl/core/bbr_bank.sv]
// One bank of the line store: single write port, registered read port.
module bbr_bank #(
	parameter int AW = 9,
	parameter int DW = 24
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem_q [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/core/bbr_div_cell.sv]
// One cell of the divider chain: resolves one quotient bit for all three channels.
module bbr_div_cell #(
	parameter int BIT = 7
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  bbr_pkg::div_t d_in,
	output bbr_pkg::div_t d_out
);

	logic [bbr_pkg::SUM_W-1:0] dvs;
	bbr_pkg::div_t             nxt;
	bbr_pkg::div_t             data_q;
	logic                      valid_q;

	assign dvs = bbr_pkg::SUM_W'(d_in.n) << BIT;

	always_comb begin
		nxt = d_in;
		for (int ch = 0; ch < bbr_pkg::NUM_CH; ch++) begin
			if (d_in.rem[ch] >= dvs) begin
				nxt.rem[ch]      = d_in.rem[ch] - dvs;
				nxt.quo[ch][BIT] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= d_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= nxt;
		end
	end

	always_comb begin
		d_out       = data_q;
		d_out.valid = valid_q;
	end

endmodule

[rtl/core/bbr_ctrl.sv]
// Frame counters, output scheduling and line store addressing.
module bbr_ctrl #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096,
	parameter int AW         = 9
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             acc,
	input  logic                             op,
	input  logic                             cfg_we,
	input  logic [bbr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bbr_pkg::CFG_W-1:0]        cfg_data,
	output bbr_pkg::ctl_t                    ctl,
	output logic [AW-1:0]                    waddr,
	output logic [2:0][AW-1:0]               raddr
);

	localparam int CW    = $clog2(MAX_WIDTH + 1);
	localparam int RW    = $clog2(MAX_HEIGHT + 1);
	localparam int RST_W = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
	localparam int RST_H = (480 > MAX_HEIGHT) ? MAX_HEIGHT : 480;

	function automatic logic [1:0] nxt3(input logic [1:0] v);
		return (v == 2'd2) ? 2'd0 : v + 2'd1;
	endfunction

	function automatic logic [1:0] prv3(input logic [1:0] v);
		return (v == 2'd0) ? 2'd2 : v - 2'd1;
	endfunction

	function automatic logic rdy(input logic [RW-1:0] ir, input logic [CW-1:0] ic,
		input logic dn, input logic [RW-1:0] r, input logic [CW-1:0] c);
		return dn || (ir > r) || ((ir == r) && (ic > c));
	endfunction

	logic [CW-1:0] w_q;
	logic [RW-1:0] h_q;
	logic [RW-1:0] in_row_q;
	logic [CW-1:0] in_col_q;
	logic          in_done_q;
	logic [1:0]    in_slot_q;
	logic [AW-1:0] in_q3_q;
	logic [1:0]    in_m3_q;
	logic [RW-1:0] out_row_q;
	logic [CW-1:0] out_col_q;
	logic [1:0]    out_slot_q;
	logic [AW-1:0] out_q3_q;
	logic [1:0]    out_m3_q;

	logic [bbr_pkg::WIDTH_W-1:0]  cfg_w;
	logic [bbr_pkg::HEIGHT_W-1:0] cfg_h;
	logic [CW-1:0] w_d;
	logic [RW-1:0] h_d;

	logic [RW-1:0] orow_inc, nr, irow_inc, in_row_p;
	logic [CW-1:0] ocol_inc, nc, icol_inc, in_col_p;
	logic          push, icol_wrap, in_done_p;
	logic          ready_pre, ready_post, emit, late;
	logic          ocol_wrap, frame_last, restart;
	logic [1:0]    rcnt, ccnt;
	logic [2:0][1:0]    rs, cb;
	logic [2:0][AW-1:0] ca;

	assign cfg_w = cfg_data[bbr_pkg::WIDTH_W-1:0];
	assign cfg_h = cfg_data[bbr_pkg::HEIGHT_W-1:0];
	assign w_d = (cfg_w == '0) ? CW'(1) :
		(int'(cfg_w) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(cfg_w);
	assign h_d = (cfg_h == '0) ? RW'(1) :
		(int'(cfg_h) > MAX_HEIGHT) ? RW'(MAX_HEIGHT) : RW'(cfg_h);

	assign orow_inc = out_row_q + RW'(1);
	assign ocol_inc = out_col_q + CW'(1);
	assign nr = (orow_inc < h_q) ? orow_inc : h_q - RW'(1);
	assign nc = (ocol_inc < w_q) ? ocol_inc : w_q - CW'(1);

	assign push      = (op == bbr_pkg::OP_PUSH) && !in_done_q;
	assign icol_inc  = in_col_q + CW'(1);
	assign icol_wrap = icol_inc >= w_q;
	assign irow_inc  = in_row_q + RW'(1);
	assign in_col_p  = push ? (icol_wrap ? '0 : icol_inc) : in_col_q;
	assign in_row_p  = (push && icol_wrap) ? irow_inc : in_row_q;
	assign in_done_p = in_done_q || (push && icol_wrap && (irow_inc >= h_q));

	assign ready_pre  = rdy(in_row_q, in_col_q, in_done_q, nr, nc);
	assign ready_post = rdy(in_row_p, in_col_p, in_done_p, nr, nc);
	assign emit       = ready_pre || ready_post;
	assign late       = !ready_pre;

	assign ocol_wrap  = ocol_inc >= w_q;
	assign frame_last = ocol_wrap && (orow_inc >= h_q);
	assign restart    = cfg_we || (acc && emit && frame_last);

	assign rs[0] = prv3(out_slot_q);
	assign rs[1] = out_slot_q;
	assign rs[2] = nxt3(out_slot_q);
	assign cb[0] = prv3(out_m3_q);
	assign cb[1] = out_m3_q;
	assign cb[2] = nxt3(out_m3_q);
	assign ca[0] = (out_m3_q == 2'd0) ? out_q3_q - AW'(1) : out_q3_q;
	assign ca[1] = out_q3_q;
	assign ca[2] = (out_m3_q == 2'd2) ? out_q3_q + AW'(1) : out_q3_q;

	assign rcnt = 2'd1 + {1'b0, out_row_q != '0} + {1'b0, orow_inc < h_q};
	assign ccnt = 2'd1 + {1'b0, out_col_q != '0} + {1'b0, ocol_inc < w_q};

	always_comb begin
		for (int b = 0; b < 3; b++) begin
			raddr[b] = ca[1];
			for (int d = 0; d < 3; d++) begin
				if (cb[d] == 2'(b)) begin
					raddr[b] = ca[d];
				end
			end
		end
	end

	always_comb begin
		ctl          = '0;
		ctl.emit     = acc && emit;
		ctl.last     = frame_last;
		ctl.n        = {2'b00, rcnt} * {2'b00, ccnt};
		ctl.row_ok   = {orow_inc < h_q, 1'b1, out_row_q != '0};
		ctl.col_ok   = {ocol_inc < w_q, 1'b1, out_col_q != '0};
		ctl.row_slot = rs;
		ctl.col_bank = cb;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				ctl.fwd[r][c] = late && push && (in_slot_q == rs[r]) &&
					(in_m3_q == cb[c]) && (in_q3_q == ca[c]);
			end
		end
		ctl.we    = acc && push;
		ctl.wslot = in_slot_q;
		ctl.wbank = in_m3_q;
	end

	assign waddr = in_q3_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q        <= CW'(RST_W);
			h_q        <= RW'(RST_H);
			in_row_q   <= '0;
			in_col_q   <= '0;
			in_done_q  <= 1'b0;
			in_slot_q  <= '0;
			in_q3_q    <= '0;
			in_m3_q    <= '0;
			out_row_q  <= '0;
			out_col_q  <= '0;
			out_slot_q <= '0;
			out_q3_q   <= '0;
			out_m3_q   <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					bbr_pkg::CFG_WIDTH:  w_q <= w_d;
					bbr_pkg::CFG_HEIGHT: h_q <= h_d;
				endcase
			end
			if (restart) begin
				in_row_q   <= '0;
				in_col_q   <= '0;
				in_done_q  <= 1'b0;
				in_slot_q  <= '0;
				in_q3_q    <= '0;
				in_m3_q    <= '0;
				out_row_q  <= '0;
				out_col_q  <= '0;
				out_slot_q <= '0;
				out_q3_q   <= '0;
				out_m3_q   <= '0;
			end else if (acc) begin
				if (push) begin
					in_done_q <= in_done_p;
					if (icol_wrap) begin
						in_col_q  <= '0;
						in_q3_q   <= '0;
						in_m3_q   <= '0;
						in_row_q  <= irow_inc;
						in_slot_q <= nxt3(in_slot_q);
					end else begin
						in_col_q <= icol_inc;
						if (in_m3_q == 2'd2) begin
							in_m3_q <= 2'd0;
							in_q3_q <= in_q3_q + AW'(1);
						end else begin
							in_m3_q <= in_m3_q + 2'd1;
						end
					end
				end
				if (emit) begin
					if (ocol_wrap) begin
						out_col_q  <= '0;
						out_q3_q   <= '0;
						out_m3_q   <= '0;
						out_row_q  <= orow_inc;
						out_slot_q <= nxt3(out_slot_q);
					end else begin
						out_col_q <= ocol_inc;
						if (out_m3_q == 2'd2) begin
							out_m3_q <= 2'd0;
							out_q3_q <= out_q3_q + AW'(1);
						end else begin
							out_m3_q <= out_m3_q + 2'd1;
						end
					end
				end
			end
		end
	end

endmodule

[rtl/core/box_blur_3x3_rgb_top.sv]
// Top level of the 3x3 RGB box blur: line store, window sums and divider chain.
//
//  channel  | direction | handshake                    | payload
//  s_axis   | in        | s_axis_tvalid/s_axis_tready  | tdata: in_pixel; tuser: operation
//  m_axis   | out       | m_axis_tvalid/m_axis_tready  | tdata: out_pixel; tlast: frame_end
//  cfg      | in        | cfg_we                       | cfg_index, cfg_data
//
//  One transaction per cycle is accepted while the pipeline is not held; a result passes through
//  the read registers, the column-sum and total registers and the eight-cell divider chain.
//  The line store is nine banks (row slot by column mod 3), one read and one write each cycle.
//  Reset clears counters and pipeline valids; the line store is not cleared.
//  The whole pipeline holds while m_axis_tvalid is high and m_axis_tready is low.
module box_blur_3x3_rgb_top #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [bbr_pkg::PIX_W-1:0]     s_axis_tdata,  // in_pixel[23:0]
	input  logic                          s_axis_tuser,  // operation
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [bbr_pkg::PIX_W-1:0]     m_axis_tdata,  // out_pixel[23:0]
	output logic                          m_axis_tlast,
	input  logic                          cfg_we,
	input  logic [bbr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bbr_pkg::CFG_W-1:0]     cfg_data
);

	localparam int AW = $clog2((MAX_WIDTH + 2) / 3 + 1);

	logic en, acc;
	bbr_pkg::ctl_t      ctl;
	logic [AW-1:0]      waddr;
	logic [2:0][AW-1:0] raddr;

	logic [2:0][2:0][bbr_pkg::PIX_W-1:0] rd_s1;
	logic                        v_s1;
	bbr_pkg::ctl_t               ctl_s1;
	logic [bbr_pkg::PIX_W-1:0]   wdata_s1;

	logic [2:0][bbr_pkg::NUM_CH-1:0][bbr_pkg::COL_W-1:0] colsum, colsum_s2;
	logic                        v_s2, last_s2;
	logic [bbr_pkg::N_W-1:0]     n_s2;

	logic [bbr_pkg::NUM_CH-1:0][bbr_pkg::SUM_W-1:0] total, total_s3;
	logic                        v_s3, last_s3;
	logic [bbr_pkg::N_W-1:0]     n_s3;

	bbr_pkg::div_t chain [bbr_pkg::CH_W+1];

	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;
	assign acc           = s_axis_tvalid && en;

	bbr_ctrl #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.AW         (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.op        (s_axis_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ctl       (ctl),
		.waddr     (waddr),
		.raddr     (raddr)
	);

	for (genvar s = 0; s < 3; s++) begin : g_slot
		for (genvar b = 0; b < 3; b++) begin : g_bank
			bbr_bank #(
				.AW (AW),
				.DW (bbr_pkg::PIX_W)
			) u_bank (
				.clk   (clk),
				.we    (ctl.we && (ctl.wslot == 2'(s)) && (ctl.wbank == 2'(b))),
				.waddr (waddr),
				.wdata (s_axis_tdata),
				.re    (en),
				.raddr (raddr[b]),
				.rdata (rd_s1[s][b])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= ctl.emit;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1    <= ctl;
			wdata_s1  <= s_axis_tdata;
			colsum_s2 <= colsum;
			last_s2   <= ctl_s1.last;
			n_s2      <= ctl_s1.n;
			total_s3  <= total;
			last_s3   <= last_s2;
			n_s3      <= n_s2;
		end
	end

	always_comb begin
		bbr_pkg::pix_t p;
		colsum = '0;
		for (int c = 0; c < 3; c++) begin
			for (int r = 0; r < 3; r++) begin
				p = ctl_s1.fwd[r][c] ? wdata_s1 :
					rd_s1[ctl_s1.row_slot[r]][ctl_s1.col_bank[c]];
				if (ctl_s1.row_ok[r] && ctl_s1.col_ok[c]) begin
					for (int ch = 0; ch < bbr_pkg::NUM_CH; ch++) begin
						colsum[c][ch] = colsum[c][ch] + bbr_pkg::COL_W'(p[ch]);
					end
				end
			end
		end
	end

	always_comb begin
		for (int ch = 0; ch < bbr_pkg::NUM_CH; ch++) begin
			total[ch] = bbr_pkg::SUM_W'(colsum_s2[0][ch]) +
				bbr_pkg::SUM_W'(colsum_s2[1][ch]) +
				bbr_pkg::SUM_W'(colsum_s2[2][ch]);
		end
	end

	always_comb begin
		chain[0].valid = v_s3;
		chain[0].last  = last_s3;
		chain[0].n     = n_s3;
		chain[0].rem   = total_s3;
		chain[0].quo   = '0;
	end

	for (genvar k = 0; k < bbr_pkg::CH_W; k++) begin : g_cell
		bbr_div_cell #(
			.BIT (bbr_pkg::CH_W - 1 - k)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.d_in   (chain[k]),
			.d_out  (chain[k+1])
		);
	end

	assign m_axis_tvalid = chain[bbr_pkg::CH_W].valid;
	assign m_axis_tdata  = chain[bbr_pkg::CH_W].quo;
	assign m_axis_tlast  = chain[bbr_pkg::CH_W].last;

endmodule
